// ===== hw/rtl/hcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcrd_pkg: shared types for the character reference decoder
// Item payloads, the controller command and datapath status bundles, and the
// emission source codes used by both halves of the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcrd_pkg;

  // Longest name that may be gathered before a named reference fails.
  localparam int MAX_NAME_LEN = 4;

  // Input item: one byte of the attribute value.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Result item: one decoded byte or the empty end marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       value_done;
  } out_t;

  // Output segments that one decode step asks for, in emission order.
  typedef struct packed {
    logic flush;  // '&' followed by the buffered reference text
    logic cp;     // UTF-8 bytes of the resolved code point
    logic lit;    // the input byte itself
    logic fin;    // end of value resolves a still open reference
    logic empty;  // end of value with no byte at all
  } plan_t;

  // Where the next result byte comes from.
  typedef enum logic [2:0] {
    SRC_AMP   = 3'd0,
    SRC_BUF   = 3'd1,
    SRC_CP    = 3'd2,
    SRC_LIT   = 3'd3,
    SRC_EMPTY = 3'd4
  } src_t;

  // Controller to datapath.
  typedef struct packed {
    logic step;    // an input item is accepted and decoded
    logic finish;  // resolve the open reference at the end of the value
    logic emit;    // load one result byte when the output register is free
    src_t src;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    plan_t step_plan;  // decode of the item at the input
    plan_t fin_plan;   // decode of the end-of-value resolution
    plan_t plan_r;     // plan of the phase being emitted
    logic  fire;       // a result byte was loaded this cycle
    logic  seg_end;    // that byte closes its segment
  } sts_t;

endpackage

// ===== hw/rtl/hcrd_datapath.sv =====
// ----------------------------------------------------------------------------
// hcrd_datapath: scan state, reference buffer and result register
// Decodes each item against the scan state, keeps the buffered reference
// text in a small memory and drives the result register byte by byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcrd_datapath #(
  parameter int MAX_DIGITS = 31
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hcrd_pkg::in_t  in_data,
  input  hcrd_pkg::cmd_t cmd,
  output hcrd_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output hcrd_pkg::out_t out_data
);

  localparam int DEPTH = MAX_DIGITS + 2;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int NUM_NAMES = 5;

  localparam logic [CNT_W:0] DIG_LIM_DEC = (CNT_W + 1)'(MAX_DIGITS + 1);
  localparam logic [CNT_W:0] DIG_LIM_HEX = (CNT_W + 1)'(MAX_DIGITS + 2);
  localparam logic [CNT_W:0] NAME_LIM    = (CNT_W + 1)'(hcrd_pkg::MAX_NAME_LEN);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  typedef enum logic [4:0] {
    M_PLAIN  = 5'b00001,
    M_AMP    = 5'b00010,
    M_HASH   = 5'b00100,
    M_DIGITS = 5'b01000,
    M_NAME   = 5'b10000
  } mode_t;

  // Known names (amp, quot, apos, lt, gt), their lengths and their bytes.
  function automatic logic [7:0] name_char(input int k, input logic [1:0] i);
    logic [31:0] w;
    case (k)
      0:       w = 32'h616d_7000;
      1:       w = 32'h7175_6f74;
      2:       w = 32'h6170_6f73;
      3:       w = 32'h6c74_0000;
      default: w = 32'h6774_0000;
    endcase
    return w[31 - 8 * i -: 8];
  endfunction

  function automatic logic [2:0] name_len(input int k);
    case (k)
      0:       return 3'd3;
      1, 2:    return 3'd4;
      default: return 3'd2;
    endcase
  endfunction

  function automatic logic [7:0] name_val(input int k);
    case (k)
      0:       return 8'h26;
      1:       return 8'h22;
      2:       return 8'h27;
      3:       return 8'h3c;
      default: return 8'h3e;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  // Scan state.
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      code_r, code_nxt;
  logic             hex_r, hex_nxt;
  logic [NUM_NAMES-1:0] cand_r, cand_nxt;

  // Item and emission state.
  logic [7:0]       c_r;
  logic             last_r;
  hcrd_pkg::plan_t  plan_r;
  logic [CNT_W-1:0] flen_r;
  logic [15:0]      cp_r;
  logic [CNT_W-1:0] pos_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       pend_mem [DEPTH];

  logic             out_valid_r;
  hcrd_pkg::out_t   out_data_r;

  // Decode signals.
  logic [7:0]           c;
  logic [NUM_NAMES-1:0] hit;
  logic [NUM_NAMES-1:0] exact;
  logic [7:0]           ref_val;
  logic                 fin_flush, fin_cp;
  logic [15:0]          fin_cpval;
  logic                 dig_hex;
  logic [15:0]          dig_base;
  logic [19:0]          dig_val;
  logic                 dig_fail;
  hcrd_pkg::plan_t      sp;
  logic [CNT_W-1:0]     sp_flen;
  logic [15:0]          sp_cp;
  logic                 push, clear, replay;

  // Emission signals.
  logic       out_free;
  logic       fire;
  logic       seg_end;
  logic       rd_go;
  logic       run_last;
  logic [7:0] e_byte;
  logic       e_has;
  logic [1:0] cp_last_idx;
  logic [7:0] cp_byte;

  assign c = in_data.in_byte;

  // Name matching: candidates that still agree with the gathered letters.
  always_comb begin
    ref_val = '0;
    for (int k = 0; k < NUM_NAMES; k++) begin
      hit[k]   = (CNT_W'(name_len(k)) > cnt_r) &&
                 (to_lower(c) == name_char(k, cnt_r[1:0]));
      exact[k] = cand_r[k] && (cnt_r == CNT_W'(name_len(k)));
      if (exact[k]) begin
        ref_val = ref_val | name_val(k);
      end
    end
  end

  // Resolution of the open reference, used by terminators and at value end.
  always_comb begin
    fin_flush = 1'b0;
    fin_cp    = 1'b0;
    fin_cpval = code_r;
    unique case (mode_r)
      M_PLAIN: begin
      end
      M_AMP, M_HASH: begin
        fin_flush = 1'b1;
      end
      M_DIGITS: begin
        if (cnt_r > (hex_r ? CNT_W'(2) : CNT_W'(1))) begin
          fin_cp = 1'b1;
        end else begin
          fin_flush = 1'b1;
        end
      end
      M_NAME: begin
        fin_cpval = {8'h00, ref_val};
        if (|exact) begin
          fin_cp = 1'b1;
        end else begin
          fin_flush = 1'b1;
        end
      end
      default: begin
        fin_flush = 1'b1;
      end
    endcase
  end

  // Digit accumulation: one multiply-by-constant and add, then a range check.
  always_comb begin
    dig_hex  = (mode_r == M_HASH) ? 1'b0 : hex_r;
    dig_base = (mode_r == M_HASH) ? 16'd0 : code_r;
    if (dig_hex) begin
      dig_val = {dig_base, 4'b0000} +
                20'(is_dec(c) ? c[3:0] : 4'(c[3:0] + 4'd9));
    end else begin
      dig_val = ({4'b0000, dig_base} << 3) + ({4'b0000, dig_base} << 1) + 20'(c[3:0]);
    end
    dig_fail = (({1'b0, cnt_r} + 1'b1) > (dig_hex ? DIG_LIM_HEX : DIG_LIM_DEC)) ||
               (dig_val[19:16] != 4'd0);
  end

  // Step decode of the item at the input against the scan state.
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    code_nxt = code_r;
    hex_nxt  = hex_r;
    cand_nxt = cand_r;
    sp       = '0;
    sp_flen  = cnt_r;
    sp_cp    = code_r;
    push     = 1'b0;
    clear    = 1'b0;
    replay   = 1'b0;

    unique case (mode_r)
      M_PLAIN: begin
        replay = 1'b1;
      end
      M_AMP: begin
        if (c == CH_HASH) begin
          push     = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          mode_nxt = M_HASH;
        end else if (is_alpha(c)) begin
          push     = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          mode_nxt = M_NAME;
          cand_nxt = hit;
          if (hit == '0) begin
            sp.flush = 1'b1;
            sp_flen  = cnt_r + 1'b1;
            clear    = 1'b1;
          end
        end else begin
          sp.flush = 1'b1;
          clear    = 1'b1;
          replay   = 1'b1;
        end
      end
      M_HASH, M_DIGITS: begin
        if ((mode_r == M_HASH) && (c == CH_X)) begin
          push     = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          hex_nxt  = 1'b1;
          code_nxt = '0;
          mode_nxt = M_DIGITS;
        end else if (dig_hex ? is_hex(c) : is_dec(c)) begin
          if (dig_fail) begin
            sp.flush = 1'b1;
            sp.lit   = 1'b1;
            clear    = 1'b1;
          end else begin
            push     = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            code_nxt = dig_val[15:0];
            hex_nxt  = dig_hex;
            mode_nxt = M_DIGITS;
          end
        end else if (mode_r == M_HASH) begin
          sp.flush = 1'b1;
          clear    = 1'b1;
          replay   = 1'b1;
        end else begin
          sp.flush = fin_flush;
          sp.cp    = fin_cp;
          sp_cp    = fin_cpval;
          clear    = 1'b1;
          replay   = !(fin_cp && (c == CH_SEMI));
        end
      end
      M_NAME: begin
        if (is_alpha(c) || is_dec(c)) begin
          if (({1'b0, cnt_r} + 1'b1) > NAME_LIM) begin
            sp.flush = 1'b1;
            sp.lit   = 1'b1;
            clear    = 1'b1;
          end else begin
            push     = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            cand_nxt = cand_r & hit;
            if ((cand_r & hit) == '0) begin
              sp.flush = 1'b1;
              sp_flen  = cnt_r + 1'b1;
              clear    = 1'b1;
            end
          end
        end else begin
          sp.flush = fin_flush;
          sp.cp    = fin_cp;
          sp_cp    = fin_cpval;
          clear    = 1'b1;
          replay   = !(fin_cp && (c == CH_SEMI));
        end
      end
      default: begin
        clear  = 1'b1;
        replay = 1'b1;
      end
    endcase

    if (clear) begin
      mode_nxt = M_PLAIN;
      cnt_nxt  = '0;
      code_nxt = '0;
      hex_nxt  = 1'b0;
      cand_nxt = '0;
    end
    // The byte that ended a reference is handled again as plain text.
    if (replay) begin
      if (c == CH_AMP) begin
        mode_nxt = M_AMP;
      end else begin
        sp.lit = 1'b1;
      end
    end

    sp.fin   = in_data.in_last && (mode_nxt != M_PLAIN);
    sp.empty = in_data.in_last && !(sp.flush || sp.cp || sp.lit || sp.fin);
  end

  // Scan state and plan registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      cnt_r  <= '0;
      code_r <= '0;
      hex_r  <= 1'b0;
      cand_r <= '0;
      plan_r <= '0;
      pos_r  <= '0;
    end else if (cmd.step) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      code_r <= code_nxt;
      hex_r  <= hex_nxt;
      cand_r <= cand_nxt;
      plan_r <= sp;
      pos_r  <= '0;
    end else if (cmd.finish) begin
      mode_r <= M_PLAIN;
      cnt_r  <= '0;
      code_r <= '0;
      hex_r  <= 1'b0;
      cand_r <= '0;
      plan_r <= '{flush: fin_flush, cp: fin_cp, lit: 1'b0, fin: 1'b0, empty: 1'b0};
      pos_r  <= '0;
    end else if (fire && (rd_go || (cmd.src == hcrd_pkg::SRC_CP))) begin
      pos_r <= pos_r + 1'b1;
    end
  end

  // Item payload and segment data.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      c_r    <= c;
      last_r <= in_data.in_last;
      flen_r <= sp_flen;
      cp_r   <= sp_cp;
    end else if (cmd.finish) begin
      flen_r <= cnt_r;
      cp_r   <= fin_cpval;
    end
  end

  // Reference text buffer: written while gathering, read while flushing.
  always_ff @(posedge clk) begin
    if (cmd.step && push) begin
      pend_mem[cnt_r[IDX_W-1:0]] <= c;
    end
    if (fire && rd_go) begin
      rd_data_r <= pend_mem[pos_r[IDX_W-1:0]];
    end
  end

  // UTF-8 byte selection for the code point.
  always_comb begin
    if (cp_r < 16'h0080) begin
      cp_last_idx = 2'd0;
      cp_byte     = cp_r[7:0];
    end else if (cp_r < 16'h0800) begin
      cp_last_idx = 2'd1;
      cp_byte     = (pos_r[1:0] == 2'd0) ? {3'b110, cp_r[10:6]} : {2'b10, cp_r[5:0]};
    end else begin
      cp_last_idx = 2'd2;
      case (pos_r[1:0])
        2'd0:    cp_byte = {4'b1110, cp_r[15:12]};
        2'd1:    cp_byte = {2'b10, cp_r[11:6]};
        default: cp_byte = {2'b10, cp_r[5:0]};
      endcase
    end
  end

  // Result byte source.
  always_comb begin
    e_byte  = c_r;
    e_has   = 1'b1;
    seg_end = 1'b1;
    rd_go   = 1'b0;
    unique case (cmd.src)
      hcrd_pkg::SRC_AMP: begin
        e_byte  = CH_AMP;
        seg_end = (flen_r == '0);
        rd_go   = (flen_r != '0);
      end
      hcrd_pkg::SRC_BUF: begin
        e_byte  = rd_data_r;
        seg_end = (pos_r == flen_r);
        rd_go   = (pos_r != flen_r);
      end
      hcrd_pkg::SRC_CP: begin
        e_byte  = cp_byte;
        seg_end = (pos_r == CNT_W'(cp_last_idx));
      end
      hcrd_pkg::SRC_LIT: begin
        e_byte = c_r;
      end
      hcrd_pkg::SRC_EMPTY: begin
        e_byte = '0;
        e_has  = 1'b0;
      end
      default: begin
      end
    endcase

    if (cmd.src == hcrd_pkg::SRC_EMPTY) begin
      run_last = 1'b1;
    end else if (cmd.src == hcrd_pkg::SRC_LIT) begin
      run_last = !plan_r.fin;
    end else begin
      run_last = seg_end && !(plan_r.lit || plan_r.fin);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = cmd.emit && out_free;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= '{out_byte: e_byte, has_byte: e_has, run_last: run_last,
                      value_done: run_last && last_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.step_plan = sp;
  assign sts.fin_plan  = '{flush: fin_flush, cp: fin_cp, lit: 1'b0, fin: 1'b0, empty: 1'b0};
  assign sts.plan_r    = plan_r;
  assign sts.fire      = fire;
  assign sts.seg_end   = seg_end;

endmodule

// ===== hw/rtl/hcrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcrd_ctrl: sequencing controller for the character reference decoder
// Accepts one item at a time and walks the datapath through the output
// segments of that item: flush, code point, literal, end-of-value, empty marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcrd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output hcrd_pkg::cmd_t cmd,
  input  hcrd_pkg::sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FL_AMP = 7'b0000010,
    S_FL_BUF = 7'b0000100,
    S_CP     = 7'b0001000,
    S_LIT    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_EMPTY  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // First segment of a freshly decoded plan.
  function automatic state_t route(input hcrd_pkg::plan_t p);
    if (p.flush) begin
      return S_FL_AMP;
    end else if (p.cp) begin
      return S_CP;
    end else if (p.lit) begin
      return S_LIT;
    end else if (p.fin) begin
      return S_FIN;
    end else if (p.empty) begin
      return S_EMPTY;
    end
    return S_IDLE;
  endfunction

  // Segment that follows a flush or a code point.
  function automatic state_t tail(input hcrd_pkg::plan_t p);
    if (p.lit) begin
      return S_LIT;
    end else if (p.fin) begin
      return S_FIN;
    end
    return S_IDLE;
  endfunction

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.src   = hcrd_pkg::SRC_LIT;
    unique case (state_r)
      S_IDLE: begin
        cmd.step = in_valid;
        if (in_valid) begin
          state_nxt = route(sts.step_plan);
        end
      end
      S_FL_AMP: begin
        cmd.emit = 1'b1;
        cmd.src  = hcrd_pkg::SRC_AMP;
        if (sts.fire) begin
          state_nxt = sts.seg_end ? tail(sts.plan_r) : S_FL_BUF;
        end
      end
      S_FL_BUF: begin
        cmd.emit = 1'b1;
        cmd.src  = hcrd_pkg::SRC_BUF;
        if (sts.fire && sts.seg_end) begin
          state_nxt = tail(sts.plan_r);
        end
      end
      S_CP: begin
        cmd.emit = 1'b1;
        cmd.src  = hcrd_pkg::SRC_CP;
        if (sts.fire && sts.seg_end) begin
          state_nxt = tail(sts.plan_r);
        end
      end
      S_LIT: begin
        cmd.emit = 1'b1;
        cmd.src  = hcrd_pkg::SRC_LIT;
        if (sts.fire) begin
          state_nxt = sts.plan_r.fin ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = route(sts.fin_plan);
      end
      S_EMPTY: begin
        cmd.emit = 1'b1;
        cmd.src  = hcrd_pkg::SRC_EMPTY;
        if (sts.fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/html_char_reference_decoder.sv =====
// ----------------------------------------------------------------------------
// html_char_reference_decoder: attribute value character reference decoder
// Bytes of an attribute value enter on the in_ channel, one per item, with
// in_last on the final byte. Each item yields zero or more result items on
// the out_ channel: literal bytes, UTF-8 bytes of a resolved reference, or
// the empty end marker. run_last flags the last result of an input item and
// value_done the last result of the whole value.
// Only one input item is in work at a time; in_stall stays high until all of
// its results are loaded into the output register. A byte copied literally
// goes from the item register into the output register. A failed reference
// flushes one result byte at a time ('&' plus the buffered text, up to
// MAX_DIGITS + 2 bytes), a code point yields 1 to 3 UTF-8 bytes, and an
// open reference closed by in_last takes one more resolve step.
// The output register frees as soon as its item is taken, so while out_stall
// is high the sequence simply waits with the current result held.
// Synchronous reset returns the decoder to plain copy mode with no output
// pending; the reference buffer needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module html_char_reference_decoder #(
  parameter int MAX_DIGITS = 31
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hcrd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hcrd_pkg::out_t out_data
);

  hcrd_pkg::cmd_t cmd;
  hcrd_pkg::sts_t sts;

  // Sequencing of the result segments.
  hcrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Scan state, buffer and result register.
  hcrd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
